// File: hdl/tccw_pkg.sv
`timescale 1ns / 1ps

package tccw_pkg;

   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 32;

   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int INDEX_W     = 11;
   localparam int CELL_W      = 16;
   localparam int POS_W       = 11;

   localparam logic [REQ_TUSER_W-1:0] REQ_PUT  = 1'b0;
   localparam logic [REQ_TUSER_W-1:0] REQ_READ = 1'b1;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL
   } state_type;

endpackage

// File: hdl/tccw_ram.sv
`timescale 1ns / 1ps

module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/text_console_char_writer.sv
`timescale 1ns / 1ps

// Text console writer with a ROWS x COLUMNS screen memory of 16-bit cells (attribute in the
// upper byte, character in the lower byte) and a cursor. A put transfer (tuser 0) writes a
// character at the cursor, or handles newline and backspace, and answers in the cycle after it
// is taken. A read transfer (tuser 1) returns one cell by way of the READ state and then the
// response register, because the single memory port has a registered read. Scrolling uses a
// rotating row base, so a put that scrolls only blanks one row afterwards, during which no
// request is taken. After reset the block blanks the whole screen, one cell per cycle,
// before it takes its first request. Each response carries the linear cursor position after
// the request.

module text_console_char_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // char_code[7:0], attribute[15:8], cell_index[26:16], zero[31:27]
   input  logic [tccw_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // req_type[0]
   input  logic [tccw_pkg::REQ_TUSER_W-1:0]      req_tuser,

   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // cell_data[15:0], cursor_pos[26:16], scrolled[27], zero[31:28]
   output logic [tccw_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);

   import tccw_pkg::*;

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int EXT_W  = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

   state_type state_ff, state_in;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] lin_ff, lin_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0] clr_end_ff, clr_end_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic              rsp_scroll_ff, rsp_scroll_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [CELL_W-1:0] mem_wdata;
   logic [CELL_W-1:0] mem_rdata;

   logic [CHAR_W-1:0]  req_char;
   logic [ATTR_W-1:0]  req_attr;
   logic [INDEX_W-1:0] req_index;

   logic              out_free;
   logic              rd_in_range;
   logic [ADDR_W-1:0] rd_phys;
   logic [ADDR_W-1:0] wr_phys;

   logic [COL_W-1:0]  put_col;
   logic [ROW_W-1:0]  put_row;
   logic [ADDR_W-1:0] put_lin;
   logic [ADDR_W:0]   lin_adv;
   logic [ADDR_W-1:0] wr_lin;
   logic [CELL_W-1:0] wr_cell;
   logic              row_adv;
   logic              do_scroll;
   logic [ADDR_W:0]   base_sum;
   logic [ADDR_W-1:0] base_nx;
   logic [EXT_W-1:0]  put_lin_ext;
   logic [EXT_W-1:0]  cur_lin_ext;

   function automatic logic [ADDR_W-1:0] to_phys(input logic [ADDR_W-1:0] lin,
                                                 input logic [ADDR_W-1:0] base);
      logic [ADDR_W:0] sum;
      sum = {1'b0, lin} + {1'b0, base};
      if (sum >= (ADDR_W+1)'(CELLS)) begin
         sum = sum - (ADDR_W+1)'(CELLS);
      end
      return sum[ADDR_W-1:0];
   endfunction

   assign req_char  = req_tdata[CHAR_W-1:0];
   assign req_attr  = req_tdata[CHAR_W+ATTR_W-1:CHAR_W];
   assign req_index = req_tdata[CHAR_W+ATTR_W+INDEX_W-1:CHAR_W+ATTR_W];

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign rd_in_range = EXT_W'(req_index) < EXT_W'(CELLS);
   assign rd_phys     = to_phys(ADDR_W'(req_index), base_ff);
   assign wr_phys     = to_phys(wr_lin, base_ff);

   always_comb begin
      put_col = col_ff;
      put_row = row_ff;
      lin_adv = {1'b0, lin_ff};
      row_adv = 1'b0;
      wr_lin  = lin_ff;
      wr_cell = {req_attr, req_char};
      if (req_char == CH_NEWLINE) begin
         put_col = '0;
         row_adv = 1'b1;
         lin_adv = {1'b0, lin_ff} + (ADDR_W+1)'(COLUMNS) - (ADDR_W+1)'(col_ff);
      end else if (req_char == CH_BACKSPACE) begin
         if (col_ff != '0) begin
            put_col = col_ff - 1'b1;
            lin_adv = {1'b0, lin_ff} - 1'b1;
         end else if (row_ff != '0) begin
            put_row = row_ff - 1'b1;
            put_col = COL_W'(COLUMNS - 1);
            lin_adv = {1'b0, lin_ff} - 1'b1;
         end
         wr_lin  = lin_adv[ADDR_W-1:0];
         wr_cell = {req_attr, CH_SPACE};
      end else begin
         lin_adv = {1'b0, lin_ff} + 1'b1;
         if (col_ff == COL_W'(COLUMNS - 1)) begin
            put_col = '0;
            row_adv = 1'b1;
         end else begin
            put_col = col_ff + 1'b1;
         end
      end

      do_scroll = row_adv && (row_ff == ROW_W'(ROWS - 1));
      if (do_scroll) begin
         put_lin = ADDR_W'(lin_adv - (ADDR_W+1)'(COLUMNS));
      end else begin
         put_lin = lin_adv[ADDR_W-1:0];
         if (row_adv) begin
            put_row = row_ff + 1'b1;
         end
      end

      base_sum = {1'b0, base_ff} + (ADDR_W+1)'(COLUMNS);
      if (base_sum == (ADDR_W+1)'(CELLS)) begin
         base_nx = '0;
      end else begin
         base_nx = base_sum[ADDR_W-1:0];
      end

      put_lin_ext = EXT_W'(put_lin);
      cur_lin_ext = EXT_W'(lin_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         col_ff        <= '0;
         row_ff        <= '0;
         lin_ff        <= '0;
         base_ff       <= '0;
         clr_addr_ff   <= '0;
         clr_end_ff    <= ADDR_W'(CELLS - 1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         lin_ff        <= lin_in;
         base_ff       <= base_in;
         clr_addr_ff   <= clr_addr_in;
         clr_end_ff    <= clr_end_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_cell_ff   <= rsp_cell_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_scroll_ff <= rsp_scroll_in;
   end

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      lin_in        = lin_ff;
      base_in       = base_ff;
      clr_addr_in   = clr_addr_ff;
      clr_end_in    = clr_end_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_cell_in   = rsp_cell_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_scroll_in = rsp_scroll_ff;
      mem_we        = 1'b0;
      mem_addr      = clr_addr_ff;
      mem_wdata     = BLANK_CELL;
      req_tready    = 1'b0;

      unique case (state_ff) inside
         ST_CLEAR, ST_SCROLL: begin
            mem_we = 1'b1;
            if (clr_addr_ff == clr_end_ff) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_tready = out_free;
            if (req_tvalid && out_free) begin
               if (req_tuser == REQ_READ) begin
                  if (rd_in_range) begin
                     mem_addr = rd_phys;
                     state_in = ST_READ;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_cell_in   = '0;
                     rsp_pos_in    = cur_lin_ext[POS_W-1:0];
                     rsp_scroll_in = 1'b0;
                  end
               end else begin
                  mem_we        = (req_char != CH_NEWLINE);
                  mem_addr      = wr_phys;
                  mem_wdata     = wr_cell;
                  col_in        = put_col;
                  row_in        = put_row;
                  lin_in        = put_lin;
                  rsp_valid_in  = 1'b1;
                  rsp_cell_in   = '0;
                  rsp_pos_in    = put_lin_ext[POS_W-1:0];
                  rsp_scroll_in = do_scroll;
                  if (do_scroll) begin
                     base_in     = base_nx;
                     clr_addr_in = base_ff;
                     clr_end_in  = ADDR_W'(base_ff + ADDR_W'(COLUMNS - 1));
                     state_in    = ST_SCROLL;
                  end
               end
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_cell_in   = mem_rdata;
            rsp_pos_in    = cur_lin_ext[POS_W-1:0];
            rsp_scroll_in = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   tccw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - CELL_W - POS_W - 1)'(0),
                        rsp_scroll_ff, rsp_pos_ff, rsp_cell_ff};

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import tccw_pkg::*;

   localparam int SCREEN_COLS      = 80;
   localparam int SCREEN_ROWS      = 25;
   localparam int SCREEN_CELLS     = SCREEN_COLS * SCREEN_ROWS;
   localparam int RANDOM_PER_PHASE = 569;
   localparam int SETTLE_CYCLES    = 2 * SCREEN_COLS + 16;
   localparam int CYCLE_LIMIT      = 1_000_000;

   typedef struct packed {
      logic [CELL_W-1:0] cell_data;
      logic [POS_W-1:0]  pos;
      logic              scrolled;
   } console_rsp_type;

   typedef struct {
      logic [REQ_TUSER_W-1:0] kind;
      logic [CHAR_W-1:0]      ch;
      logic [ATTR_W-1:0]      attr;
      logic [INDEX_W-1:0]     idx;
      int                     reps;
      bit                     typed;
      console_rsp_type        want;
   } plan_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = REQ_PUT;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // The expected result typed into the table travels along with the transfer.
   bit                     item_typed = 1'b0;
   console_rsp_type        item_want  = '0;

   logic [CELL_W-1:0] screen_cells [SCREEN_CELLS];
   int                cur_col = 0;
   int                cur_row = 0;

   console_rsp_type console_rsp_q [$];
   plan_row_type    plan [$];

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int n_issued      = 0;
   int n_rsp         = 0;
   int n_puts        = 0;
   int n_reads       = 0;
   int n_scrolls     = 0;
   int n_errors      = 0;
   int cycle_count   = 0;

   text_console_char_writer #(
      .COLUMNS(SCREEN_COLS),
      .ROWS   (SCREEN_ROWS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic console_rsp_type console_step(logic [REQ_TUSER_W-1:0] kind,
                                                    logic [CHAR_W-1:0] ch,
                                                    logic [ATTR_W-1:0] attr,
                                                    logic [INDEX_W-1:0] idx);
      console_rsp_type r;
      r = '0;
      if (kind == REQ_READ) begin
         if (idx < SCREEN_CELLS) begin
            r.cell_data = screen_cells[idx];
         end
      end else begin
         if (ch == CH_NEWLINE) begin
            cur_col = 0;
            cur_row++;
         end else if (ch == CH_BACKSPACE) begin
            if (cur_col > 0) begin
               cur_col--;
            end else if (cur_row > 0) begin
               cur_row--;
               cur_col = SCREEN_COLS - 1;
            end
            screen_cells[cur_row * SCREEN_COLS + cur_col] = {attr, CH_SPACE};
         end else begin
            screen_cells[cur_row * SCREEN_COLS + cur_col] = {attr, ch};
            cur_col++;
         end
         if (cur_col >= SCREEN_COLS) begin
            cur_col = 0;
            cur_row++;
         end
         if (cur_row >= SCREEN_ROWS) begin
            for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++) begin
               screen_cells[i] = screen_cells[i + SCREEN_COLS];
            end
            for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++) begin
               screen_cells[i] = BLANK_CELL;
            end
            cur_row = SCREEN_ROWS - 1;
            r.scrolled = 1'b1;
         end
      end
      r.pos = POS_W'(cur_row * SCREEN_COLS + cur_col);
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      console_rsp_type got;
      console_rsp_type want;
      cycle_count++;
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      if (req_tvalid && req_tready) begin
         got = console_step(req_tuser, req_tdata[7:0], req_tdata[15:8], req_tdata[26:16]);
         console_rsp_q.push_back(item_typed ? item_want : got);
         if (req_tuser == REQ_READ) begin
            n_reads++;
         end else begin
            n_puts++;
         end
      end
      if (rsp_tvalid && rsp_tready) begin
         n_rsp++;
         got.cell_data = rsp_tdata[15:0];
         got.pos       = rsp_tdata[26:16];
         got.scrolled  = rsp_tdata[27];
         if (console_rsp_q.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected transfer, actual %h", $time, rsp_tdata);
         end else begin
            want = console_rsp_q.pop_front();
            if (got.scrolled) begin
               n_scrolls++;
            end
            if (got.cell_data !== want.cell_data) begin
               n_errors++;
               $display("%0t: cell_data expected %h actual %h", $time, want.cell_data,
                        got.cell_data);
            end
            if (got.pos !== want.pos) begin
               n_errors++;
               $display("%0t: cursor_pos expected %0d actual %0d", $time, want.pos, got.pos);
            end
            if (got.scrolled !== want.scrolled) begin
               n_errors++;
               $display("%0t: scrolled expected %b actual %b", $time, want.scrolled,
                        got.scrolled);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
      end
      $display("Timed out after %0d cycles.", cycle_count);
      $display("text_console_char_writer test failed");
      $finish;
   end

   function automatic void add_row(logic [REQ_TUSER_W-1:0] kind, logic [CHAR_W-1:0] ch,
                                   logic [ATTR_W-1:0] attr, logic [INDEX_W-1:0] idx,
                                   int reps, bit typed, logic [CELL_W-1:0] cell_data,
                                   logic [POS_W-1:0] pos, logic scrolled);
      plan_row_type row;
      row.kind  = kind;
      row.ch    = ch;
      row.attr  = attr;
      row.idx   = idx;
      row.reps  = reps;
      row.typed = typed;
      row.want  = '{cell_data: cell_data, pos: pos, scrolled: scrolled};
      plan.push_back(row);
   endfunction

   task automatic send_transfer(logic [REQ_TUSER_W-1:0] kind, logic [CHAR_W-1:0] ch,
                                logic [ATTR_W-1:0] attr, logic [INDEX_W-1:0] idx,
                                bit typed, console_rsp_type want);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, idx, attr, ch};
      item_typed <= typed;
      item_want  <= want;
      do @(posedge clock); while (!req_tready);
      n_issued++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (n_rsp < n_issued);
   endtask

   initial begin : stimulus
      logic [REQ_TUSER_W-1:0] kind;
      logic [CHAR_W-1:0]      ch;
      logic [ATTR_W-1:0]      attr;
      logic [INDEX_W-1:0]     idx;
      int                     pick;
      int                     nl_pct;
      int                     near;

      for (int i = 0; i < SCREEN_CELLS; i++) begin
         screen_cells[i] = BLANK_CELL;
      end

      add_row(REQ_READ, 8'h00, 8'h00, 11'd0,    1, 1, BLANK_CELL, 11'd0, 1'b0);
      add_row(REQ_READ, 8'h00, 8'h00, 11'd1999, 1, 1, BLANK_CELL, 11'd0, 1'b0);
      add_row(REQ_READ, 8'h00, 8'h00, 11'd2000, 1, 1, 16'h0000,   11'd0, 1'b0);
      add_row(REQ_READ, 8'hFF, 8'hFF, 11'd2047, 1, 1, 16'h0000,   11'd0, 1'b0);
      // Backspace with the cursor at home blanks cell 0 and stays put.
      add_row(REQ_PUT,  CH_BACKSPACE, 8'h1F, 11'd0, 1, 1, 16'h0000, 11'd0, 1'b0);
      add_row(REQ_READ, 8'h00, 8'h00, 11'd0,    1, 1, 16'h1F20,   11'd0, 1'b0);
      add_row(REQ_PUT,  8'h41, 8'hFF, 11'd2047, 1, 1, 16'h0000,   11'd1, 1'b0);
      add_row(REQ_PUT,  8'hFF, 8'h00, 11'd0,    1, 1, 16'h0000,   11'd2, 1'b0);
      add_row(REQ_PUT,  8'h00, 8'h80, 11'd0,    1, 1, 16'h0000,   11'd3, 1'b0);
      add_row(REQ_PUT,  CH_NEWLINE, 8'h55, 11'd0, 1, 1, 16'h0000, 11'd80, 1'b0);
      // Backspace at the start of a row goes to the last column of the row above.
      add_row(REQ_PUT,  CH_BACKSPACE, 8'h4E, 11'd0, 1, 1, 16'h0000, 11'd79, 1'b0);
      add_row(REQ_READ, 8'h00, 8'h00, 11'd79,   1, 1, 16'h4E20,   11'd79, 1'b0);
      add_row(REQ_READ, 8'h00, 8'h00, 11'd0,    1, 1, 16'hFF41,   11'd79, 1'b0);
      add_row(REQ_READ, 8'h00, 8'h00, 11'd2,    1, 1, 16'h8000,   11'd79, 1'b0);
      // A character in the last column wraps the cursor to the next row.
      add_row(REQ_PUT,  8'h0E, 8'h0F, 11'd0,    1, 1, 16'h0000,   11'd80, 1'b0);
      add_row(REQ_PUT,  CH_NEWLINE, 8'hAA, 11'd0, 23, 0, 16'h0000, 11'd0, 1'b0);
      // A newline on the bottom row scrolls the screen up.
      add_row(REQ_PUT,  CH_NEWLINE, 8'h00, 11'd0, 1, 1, 16'h0000, 11'd1920, 1'b1);
      add_row(REQ_READ, 8'h00, 8'h00, 11'd1920, 1, 1, BLANK_CELL, 11'd1920, 1'b0);
      add_row(REQ_READ, 8'h00, 8'h00, 11'd0,    1, 0, 16'h0000,   11'd0, 1'b0);
      add_row(REQ_PUT,  CH_BACKSPACE, 8'h71, 11'd0, 1, 0, 16'h0000, 11'd0, 1'b0);
      add_row(REQ_READ, 8'h00, 8'h00, 11'd1919, 1, 0, 16'h0000,   11'd0, 1'b0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 7;
      rsp_idle_pct  = 77;
      foreach (plan[r]) begin
         for (int k = 0; k < plan[r].reps; k++) begin
            send_transfer(plan[r].kind, plan[r].ch, plan[r].attr, plan[r].idx,
                          plan[r].typed && plan[r].reps == 1, plan[r].want);
         end
      end
      drain_results();

      nl_pct = 4;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 7;
               rsp_idle_pct  = 77;
            end
            1: begin
               send_idle_pct = 77;
               rsp_idle_pct  = 7;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            // Long lines at a low newline rate reach the column wrap; short ones scroll often.
            if (k % 200 == 0) begin
               case ($urandom_range(2))
                  0: nl_pct = 1;
                  1: nl_pct = 4;
                  default: nl_pct = 15;
               endcase
            end
            pick = $urandom_range(99);
            kind = REQ_PUT;
            ch   = CHAR_W'($urandom_range(255));
            attr = ATTR_W'($urandom_range(255));
            idx  = INDEX_W'($urandom_range(2047));
            if (pick < nl_pct) begin
               ch = CH_NEWLINE;
            end else if (pick < nl_pct + 6) begin
               ch = CH_BACKSPACE;
            end else if (pick >= 65) begin
               kind = REQ_READ;
               case ($urandom_range(7)) inside
                  0: idx = INDEX_W'($urandom_range(2047, SCREEN_CELLS));
                  [1:3]: begin
                     near = cur_row * SCREEN_COLS + cur_col - $urandom_range(40);
                     if (near < 0) begin
                        near += SCREEN_CELLS;
                     end
                     idx = INDEX_W'(near);
                  end
                  default: idx = INDEX_W'($urandom_range(SCREEN_CELLS - 1));
               endcase
            end
            send_transfer(kind, ch, attr, idx, 1'b0, '0);
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (console_rsp_q.size() != 0) begin
         n_errors++;
         $display("%0t: %0d expected results never arrived", $time, console_rsp_q.size());
      end
      $display("Sent %0d transfers (%0d puts, %0d reads), checked %0d results.",
               n_issued, n_puts, n_reads, n_rsp);
      $display("Saw %0d scrolls over %0d cycles under three idling mixes.",
               n_scrolls, cycle_count);
      if (n_errors == 0) begin
         $display("text_console_char_writer test passed");
      end else begin
         $display("text_console_char_writer test failed");
      end
      $finish;
   end

endmodule
